@@ rtl/core/ltu_pkg.sv @@
// shared constants, codes and helpers for the lattice run-and-tumble update block
package ltu_pkg;

	localparam int GRID_X        = 128;
	localparam int GRID_Y        = 64;
	localparam int SITE_LIMIT    = 3;
	localparam int MAX_PARTICLES = 32768;

	localparam int X_W       = $clog2(GRID_X);
	localparam int Y_W       = $clog2(GRID_Y);
	localparam int IDX_W     = $clog2(MAX_PARTICLES);
	localparam int CNT_W     = $clog2(SITE_LIMIT + 1);
	localparam int SITE_NUM  = GRID_X * GRID_Y;
	localparam int SITE_AW   = $clog2(SITE_NUM);
	localparam int DIR_W     = 2;
	localparam int REC_W     = X_W + Y_W + DIR_W;
	localparam int PROB_W    = 17;
	localparam int RAND_W    = 16;

	localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(65536);
	localparam logic [PROB_W-1:0] PROB_HALF = PROB_W'(32768);

	typedef enum logic [1:0] {
		OP_PLACE = 2'd0,
		OP_LOAD  = 2'd1,
		OP_STEP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_ALWAYS = 2'd0,
		MODE_TABLE  = 2'd1,
		MODE_XONLY  = 2'd2,
		MODE_SPARE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		DIR_PX = 2'd0,
		DIR_PY = 2'd1,
		DIR_MX = 2'd2,
		DIR_MY = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BLOCKED  = 2'd1,
		ST_REJECTED = 2'd2,
		ST_SPARE    = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_MODE   = 1'd0,
		REG_TUMBLE = 1'd1
	} reg_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PLACE,
		S_UPD_RD,
		S_UPD_TGT,
		S_UPD_SRC,
		S_UPD_INC
	} state_t;

	function automatic logic [SITE_AW-1:0] site_addr(input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y);
		site_addr = SITE_AW'(x) * SITE_AW'(GRID_Y) + SITE_AW'(y);
	endfunction

endpackage

@@ rtl/core/ltu_ram.sv @@
// generic single write port ram with one registered read port
module ltu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/lattice_run_tumble_update_top.sv @@
// top level of the lattice run-and-tumble update block
//
// channel   direction  handshake                       payload
// command   in         start && !busy                  op .. rand_direction
// result    out        done (one cycle, no stall)      out_x .. status
// config    in         psel && penable && pwrite       paddr, pwdata, prdata
//
// place goes through S_PLACE, column load and spare op complete in S_IDLE; an update goes
// through S_UPD_RD and S_UPD_TGT and, when the particle moves, S_UPD_SRC and S_UPD_INC, as the
// single read port of the site count ram forces (target count, then source count, then two writes).
// after reset all 8192 entries of the site count ram are swept to zero with busy high.
// done is registered and rises in the cycle after the last state of a word; the receiver cannot stall.
module lattice_run_tumble_update_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [14:0] particle_index,
	input  logic [6:0]  site_x,
	input  logic [5:0]  site_y,
	input  logic [1:0]  direction_in,
	input  logic [16:0] column_prob,
	input  logic [15:0] rand_move,
	input  logic [15:0] rand_tumble,
	input  logic [1:0]  rand_direction,
	output logic        done,
	output logic [6:0]  out_x,
	output logic [5:0]  out_y,
	output logic [1:0]  out_direction,
	output logic        moved,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ltu_pkg::state_t state_q, state_d;

	logic [1:0]                    mode_q;
	logic [ltu_pkg::PROB_W-1:0]    tumble_q;

	logic [ltu_pkg::IDX_W-1:0]     idx_q;
	logic [ltu_pkg::X_W-1:0]       sx_q;
	logic [ltu_pkg::Y_W-1:0]       sy_q;
	logic [ltu_pkg::DIR_W-1:0]     din_q;
	logic [ltu_pkg::RAND_W-1:0]    rmove_q;
	logic [ltu_pkg::RAND_W-1:0]    rtumb_q;
	logic [ltu_pkg::DIR_W-1:0]     rdir_q;

	logic [ltu_pkg::X_W-1:0]       x0_q, x1_q, nx;
	logic [ltu_pkg::Y_W-1:0]       y0_q, y1_q, ny;
	logic [ltu_pkg::DIR_W-1:0]     d_q, dn_q, dnew;
	logic [ltu_pkg::CNT_W-1:0]     tgt_cnt_q;
	logic [ltu_pkg::SITE_AW-1:0]   clr_q;

	logic                          site_we;
	logic [ltu_pkg::SITE_AW-1:0]   site_waddr, site_raddr;
	logic [ltu_pkg::CNT_W-1:0]     site_wdata, site_rdata;
	logic                          part_we;
	logic [ltu_pkg::IDX_W-1:0]     part_waddr, part_raddr;
	logic [ltu_pkg::REC_W-1:0]     part_wdata, part_rdata;
	logic                          col_we;
	logic [ltu_pkg::X_W-1:0]       col_waddr, col_raddr;
	logic [ltu_pkg::PROB_W-1:0]    col_wdata, col_rdata;

	logic                          accept;
	logic                          cfg_we;
	logic                          res_load;
	logic [ltu_pkg::X_W-1:0]       res_x_d, out_x_q;
	logic [ltu_pkg::Y_W-1:0]       res_y_d, out_y_q;
	logic [ltu_pkg::DIR_W-1:0]     res_d_d, out_d_q;
	logic                          res_m_d, moved_q, done_q;
	logic [1:0]                    res_s_d, status_q;

	logic [ltu_pkg::X_W-1:0]       rx;
	logic [ltu_pkg::Y_W-1:0]       ry;
	logic [ltu_pkg::DIR_W-1:0]     rd;
	logic                          avail, go, tumble;
	logic [ltu_pkg::PROB_W-1:0]    prob;

	assign busy   = (state_q != ltu_pkg::S_IDLE);
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	assign rx = part_rdata[ltu_pkg::REC_W-1 -: ltu_pkg::X_W];
	assign ry = part_rdata[ltu_pkg::DIR_W +: ltu_pkg::Y_W];
	assign rd = part_rdata[ltu_pkg::DIR_W-1:0];

	always_comb begin
		nx = rx;
		ny = ry;
		unique case (ltu_pkg::dir_t'(rd))
			ltu_pkg::DIR_PX: nx = (rx == ltu_pkg::X_W'(ltu_pkg::GRID_X - 1)) ? '0 : rx + 1'b1;
			ltu_pkg::DIR_PY: ny = (ry == ltu_pkg::Y_W'(ltu_pkg::GRID_Y - 1)) ? '0 : ry + 1'b1;
			ltu_pkg::DIR_MX: nx = (rx == '0) ? ltu_pkg::X_W'(ltu_pkg::GRID_X - 1) : rx - 1'b1;
			ltu_pkg::DIR_MY: ny = (ry == '0) ? ltu_pkg::Y_W'(ltu_pkg::GRID_Y - 1) : ry - 1'b1;
		endcase
	end

	always_comb begin
		unique case (ltu_pkg::mode_t'(mode_q))
			ltu_pkg::MODE_TABLE: prob = col_rdata;
			ltu_pkg::MODE_XONLY: prob = d_q[0] ? ltu_pkg::PROB_HALF : col_rdata;
			ltu_pkg::MODE_ALWAYS,
			ltu_pkg::MODE_SPARE: prob = ltu_pkg::PROB_ONE;
		endcase
	end

	assign avail  = (site_rdata < ltu_pkg::CNT_W'(ltu_pkg::SITE_LIMIT));
	assign go     = avail && ({1'b0, rmove_q} < prob);
	assign tumble = ({1'b0, rtumb_q} < tumble_q);
	assign dnew   = tumble ? rdir_q : d_q;

	always_comb begin
		state_d    = state_q;
		site_we    = 1'b0;
		site_waddr = ltu_pkg::site_addr(x1_q, y1_q);
		site_wdata = tgt_cnt_q + 1'b1;
		site_raddr = ltu_pkg::site_addr(site_x, site_y);
		part_we    = 1'b0;
		part_waddr = idx_q;
		part_wdata = {x1_q, y1_q, dn_q};
		part_raddr = particle_index;
		col_we     = 1'b0;
		col_waddr  = site_x;
		col_wdata  = (column_prob > ltu_pkg::PROB_ONE) ? ltu_pkg::PROB_ONE : column_prob;
		col_raddr  = nx;
		res_load   = 1'b0;
		res_x_d    = '0;
		res_y_d    = '0;
		res_d_d    = '0;
		res_m_d    = 1'b0;
		res_s_d    = ltu_pkg::ST_OK;
		unique case (state_q)
			ltu_pkg::S_CLEAR: begin
				site_we    = 1'b1;
				site_waddr = clr_q;
				site_wdata = '0;
				if (clr_q == ltu_pkg::SITE_AW'(ltu_pkg::SITE_NUM - 1)) begin
					state_d = ltu_pkg::S_IDLE;
				end
			end
			ltu_pkg::S_IDLE: begin
				if (accept) begin
					unique case (ltu_pkg::op_t'(op))
						ltu_pkg::OP_PLACE: state_d = ltu_pkg::S_PLACE;
						ltu_pkg::OP_STEP:  state_d = ltu_pkg::S_UPD_RD;
						ltu_pkg::OP_LOAD: begin
							col_we   = 1'b1;
							res_load = 1'b1;
						end
						ltu_pkg::OP_NONE: res_load = 1'b1;
					endcase
				end
			end
			ltu_pkg::S_PLACE: begin
				res_load = 1'b1;
				res_x_d  = sx_q;
				res_y_d  = sy_q;
				res_d_d  = din_q;
				if (avail) begin
					site_we    = 1'b1;
					site_waddr = ltu_pkg::site_addr(sx_q, sy_q);
					site_wdata = site_rdata + 1'b1;
					part_we    = 1'b1;
					part_wdata = {sx_q, sy_q, din_q};
				end else begin
					res_s_d = ltu_pkg::ST_REJECTED;
				end
				state_d = ltu_pkg::S_IDLE;
			end
			ltu_pkg::S_UPD_RD: begin
				site_raddr = ltu_pkg::site_addr(nx, ny);
				state_d    = ltu_pkg::S_UPD_TGT;
			end
			ltu_pkg::S_UPD_TGT: begin
				if (go) begin
					site_raddr = ltu_pkg::site_addr(x0_q, y0_q);
					state_d    = ltu_pkg::S_UPD_SRC;
				end else begin
					part_we    = tumble;
					part_wdata = {x0_q, y0_q, rdir_q};
					res_load   = 1'b1;
					res_x_d    = x0_q;
					res_y_d    = y0_q;
					res_d_d    = dnew;
					res_s_d    = avail ? ltu_pkg::ST_OK : ltu_pkg::ST_BLOCKED;
					state_d    = ltu_pkg::S_IDLE;
				end
			end
			ltu_pkg::S_UPD_SRC: begin
				site_we    = 1'b1;
				site_waddr = ltu_pkg::site_addr(x0_q, y0_q);
				site_wdata = (site_rdata != '0) ? site_rdata - 1'b1 : '0;
				part_we    = 1'b1;
				state_d    = ltu_pkg::S_UPD_INC;
			end
			ltu_pkg::S_UPD_INC: begin
				site_we  = 1'b1;
				res_load = 1'b1;
				res_x_d  = x1_q;
				res_y_d  = y1_q;
				res_d_d  = dn_q;
				res_m_d  = 1'b1;
				state_d  = ltu_pkg::S_IDLE;
			end
			default: state_d = ltu_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ltu_pkg::S_CLEAR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			mode_q   <= '0;
			tumble_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
			if (state_q == ltu_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (ltu_pkg::reg_t'(paddr[2]))
					ltu_pkg::REG_MODE:   mode_q   <= pwdata[1:0];
					ltu_pkg::REG_TUMBLE: tumble_q <= pwdata[ltu_pkg::PROB_W-1:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= particle_index;
			sx_q    <= site_x;
			sy_q    <= site_y;
			din_q   <= direction_in;
			rmove_q <= rand_move;
			rtumb_q <= rand_tumble;
			rdir_q  <= rand_direction;
		end
		if (state_q == ltu_pkg::S_UPD_RD) begin
			x0_q <= rx;
			y0_q <= ry;
			d_q  <= rd;
			x1_q <= nx;
			y1_q <= ny;
		end
		if (state_q == ltu_pkg::S_UPD_TGT) begin
			tgt_cnt_q <= site_rdata;
			dn_q      <= dnew;
		end
		if (res_load) begin
			out_x_q  <= res_x_d;
			out_y_q  <= res_y_d;
			out_d_q  <= res_d_d;
			moved_q  <= res_m_d;
			status_q <= res_s_d;
		end
	end

	always_comb begin
		prdata = '0;
		unique case (ltu_pkg::reg_t'(paddr[2]))
			ltu_pkg::REG_MODE:   prdata[1:0] = mode_q;
			ltu_pkg::REG_TUMBLE: prdata[ltu_pkg::PROB_W-1:0] = tumble_q;
		endcase
	end

	assign done          = done_q;
	assign out_x         = out_x_q;
	assign out_y         = out_y_q;
	assign out_direction = out_d_q;
	assign moved         = moved_q;
	assign status        = status_q;

	ltu_ram #(
		.WIDTH(ltu_pkg::CNT_W),
		.DEPTH(ltu_pkg::SITE_NUM)
	) u_site_ram (
		.clk  (clk),
		.we   (site_we),
		.waddr(site_waddr),
		.wdata(site_wdata),
		.raddr(site_raddr),
		.rdata(site_rdata)
	);

	ltu_ram #(
		.WIDTH(ltu_pkg::REC_W),
		.DEPTH(ltu_pkg::MAX_PARTICLES)
	) u_part_ram (
		.clk  (clk),
		.we   (part_we),
		.waddr(part_waddr),
		.wdata(part_wdata),
		.raddr(part_raddr),
		.rdata(part_rdata)
	);

	ltu_ram #(
		.WIDTH(ltu_pkg::PROB_W),
		.DEPTH(ltu_pkg::GRID_X)
	) u_col_ram (
		.clk  (clk),
		.we   (col_we),
		.waddr(col_waddr),
		.wdata(col_wdata),
		.raddr(col_raddr),
		.rdata(col_rdata)
	);

endmodule

@@ bench/lattice_run_tumble_update_top_tb.sv @@
// testbench for the lattice run-and-tumble update block with a lattice predictor
`timescale 1ns / 100ps
module lattice_run_tumble_update_top_tb;

	typedef struct {
		ltu_pkg::op_t               op;
		logic [ltu_pkg::IDX_W-1:0]  idx;
		logic [ltu_pkg::X_W-1:0]    x;
		logic [ltu_pkg::Y_W-1:0]    y;
		ltu_pkg::dir_t              dir;
		logic [ltu_pkg::PROB_W-1:0] cprob;
		logic [ltu_pkg::RAND_W-1:0] rmove;
		logic [ltu_pkg::RAND_W-1:0] rtumb;
		ltu_pkg::dir_t              rdir;
	} word_t;

	typedef struct {
		logic [ltu_pkg::X_W-1:0] x;
		logic [ltu_pkg::Y_W-1:0] y;
		ltu_pkg::dir_t           dir;
		logic                    moved;
		ltu_pkg::status_t        st;
	} lattice_res_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = '0;
	logic [14:0] particle_index = '0;
	logic [6:0]  site_x = '0;
	logic [5:0]  site_y = '0;
	logic [1:0]  direction_in = '0;
	logic [16:0] column_prob = '0;
	logic [15:0] rand_move = '0;
	logic [15:0] rand_tumble = '0;
	logic [1:0]  rand_direction = '0;
	logic        done;
	logic [6:0]  out_x;
	logic [5:0]  out_y;
	logic [1:0]  out_direction;
	logic        moved;
	logic [1:0]  status;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// lattice predictor state
	logic [ltu_pkg::CNT_W-1:0]  occupancy [ltu_pkg::SITE_NUM];
	logic [ltu_pkg::X_W-1:0]    pos_x [ltu_pkg::MAX_PARTICLES];
	logic [ltu_pkg::Y_W-1:0]    pos_y [ltu_pkg::MAX_PARTICLES];
	ltu_pkg::dir_t              heading [ltu_pkg::MAX_PARTICLES];
	bit                         is_placed [ltu_pkg::MAX_PARTICLES];
	logic [ltu_pkg::PROB_W-1:0] col_prob [ltu_pkg::GRID_X];
	ltu_pkg::mode_t             cur_mode = ltu_pkg::MODE_ALWAYS;
	logic [ltu_pkg::PROB_W-1:0] cur_tumble = '0;
	int                         placed_q [$];

	word_t        pending [$];
	lattice_res_t expected [$];
	int           queued_cnt = 0;
	int           accepted_cnt = 0;
	int           err_cnt = 0;
	int           idle_pct = 0;
	logic         took = 1'b0;

	lattice_run_tumble_update_top i_dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic lattice_res_t lattice_update(input word_t w);
		lattice_res_t                r;
		logic [ltu_pkg::SITE_AW-1:0] here, there;
		logic [ltu_pkg::X_W-1:0]     nx;
		logic [ltu_pkg::Y_W-1:0]     ny;
		logic [ltu_pkg::PROB_W-1:0]  p;
		ltu_pkg::dir_t               d;
		r.x = '0;
		r.y = '0;
		r.dir = ltu_pkg::DIR_PX;
		r.moved = 1'b0;
		r.st = ltu_pkg::ST_OK;
		case (w.op)
			ltu_pkg::OP_PLACE: begin
				here = {w.x, w.y};
				r.x = w.x;
				r.y = w.y;
				r.dir = w.dir;
				if (occupancy[here] >= ltu_pkg::SITE_LIMIT) begin
					r.st = ltu_pkg::ST_REJECTED;
				end else begin
					pos_x[w.idx] = w.x;
					pos_y[w.idx] = w.y;
					heading[w.idx] = w.dir;
					occupancy[here]++;
					if (!is_placed[w.idx]) begin
						is_placed[w.idx] = 1'b1;
						placed_q.push_back(w.idx);
					end
				end
			end
			ltu_pkg::OP_LOAD:
				col_prob[w.x] = (w.cprob > ltu_pkg::PROB_ONE) ? ltu_pkg::PROB_ONE : w.cprob;
			ltu_pkg::OP_STEP: begin
				nx = pos_x[w.idx];
				ny = pos_y[w.idx];
				d = heading[w.idx];
				here = {nx, ny};
				r.x = nx;
				r.y = ny;
				case (d)
					ltu_pkg::DIR_PX: nx = nx + 1'b1;
					ltu_pkg::DIR_PY: ny = ny + 1'b1;
					ltu_pkg::DIR_MX: nx = nx - 1'b1;
					default: ny = ny - 1'b1;
				endcase
				there = {nx, ny};
				if (occupancy[there] < ltu_pkg::SITE_LIMIT) begin
					case (cur_mode)
						ltu_pkg::MODE_TABLE: p = col_prob[nx];
						ltu_pkg::MODE_XONLY:
							p = (d == ltu_pkg::DIR_PY || d == ltu_pkg::DIR_MY) ?
								ltu_pkg::PROB_HALF : col_prob[nx];
						default: p = ltu_pkg::PROB_ONE;
					endcase
					if ({1'b0, w.rmove} < p) begin
						if (occupancy[here] != 0)
							occupancy[here]--;
						occupancy[there]++;
						pos_x[w.idx] = nx;
						pos_y[w.idx] = ny;
						r.x = nx;
						r.y = ny;
						r.moved = 1'b1;
					end
				end else begin
					r.st = ltu_pkg::ST_BLOCKED;
				end
				if ({1'b0, w.rtumb} < cur_tumble)
					d = w.rdir;
				heading[w.idx] = d;
				r.dir = d;
			end
			default: ;
		endcase
		return r;
	endfunction

	// result check and prediction on each accepted word
	always @(posedge clk) begin
		word_t        seen;
		lattice_res_t want;
		if (arst_n) begin
			if (done) begin
				if (expected.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result: x=%0d y=%0d dir=%0d moved=%0d status=%0d",
							out_x, out_y, out_direction, moved, status);
				end else begin
					want = expected.pop_front();
					if (out_x !== want.x || out_y !== want.y || out_direction !== want.dir ||
							moved !== want.moved || status !== want.st) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: expected x=%0d y=%0d dir=%0d moved=%0d status=%0d, %s",
								want.x, want.y, want.dir, want.moved, want.st,
								$sformatf("got x=%0d y=%0d dir=%0d moved=%0d status=%0d",
									out_x, out_y, out_direction, moved, status));
					end
				end
			end
			if (start && !busy) begin
				seen.op = ltu_pkg::op_t'(op);
				seen.idx = particle_index;
				seen.x = site_x;
				seen.y = site_y;
				seen.dir = ltu_pkg::dir_t'(direction_in);
				seen.cprob = column_prob;
				seen.rmove = rand_move;
				seen.rtumb = rand_tumble;
				seen.rdir = ltu_pkg::dir_t'(rand_direction);
				expected.push_back(lattice_update(seen));
				accepted_cnt++;
			end
		end
		took <= arst_n && start && !busy;
	end

	// command driver
	always @(negedge clk) begin
		word_t w;
		if (arst_n && (!start || took)) begin
			if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
				w = pending.pop_front();
				op <= w.op;
				particle_index <= w.idx;
				site_x <= w.x;
				site_y <= w.y;
				direction_in <= w.dir;
				column_prob <= w.cprob;
				rand_move <= w.rmove;
				rand_tumble <= w.rtumb;
				rand_direction <= w.rdir;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic word_t make_word(input ltu_pkg::op_t o, input int idx, input int x,
			input int y, input ltu_pkg::dir_t d, input int cprob, input int rmove,
			input int rtumb, input ltu_pkg::dir_t rd);
		word_t w;
		w.op = o;
		w.idx = ltu_pkg::IDX_W'(idx);
		w.x = ltu_pkg::X_W'(x);
		w.y = ltu_pkg::Y_W'(y);
		w.dir = d;
		w.cprob = ltu_pkg::PROB_W'(cprob);
		w.rmove = ltu_pkg::RAND_W'(rmove);
		w.rtumb = ltu_pkg::RAND_W'(rtumb);
		w.rdir = rd;
		return w;
	endfunction

	function automatic logic [ltu_pkg::PROB_W-1:0] pick_prob();
		case ($urandom_range(7))
			0: return '0;
			1: return ltu_pkg::PROB_ONE;
			2: return ltu_pkg::PROB_W'($urandom_range(131071, 65537));
			default: return ltu_pkg::PROB_W'($urandom_range(65536));
		endcase
	endfunction

	function automatic word_t random_word();
		word_t w;
		int    pick;
		pick = $urandom_range(99);
		w.op = ltu_pkg::OP_NONE;
		w.idx = ltu_pkg::IDX_W'($urandom_range(ltu_pkg::MAX_PARTICLES - 1));
		w.x = ltu_pkg::X_W'($urandom_range(ltu_pkg::GRID_X - 1));
		w.y = ltu_pkg::Y_W'($urandom_range(ltu_pkg::GRID_Y - 1));
		w.dir = ltu_pkg::dir_t'($urandom_range(3));
		w.cprob = ltu_pkg::PROB_W'($urandom_range(131071));
		w.rdir = ltu_pkg::dir_t'($urandom_range(3));
		case ($urandom_range(7))
			0: w.rmove = ltu_pkg::RAND_W'(32767);
			1: w.rmove = ltu_pkg::RAND_W'(32768);
			2: w.rmove = '0;
			3: w.rmove = '1;
			default: w.rmove = ltu_pkg::RAND_W'($urandom_range(65535));
		endcase
		case ($urandom_range(7))
			0: w.rtumb = cur_tumble[ltu_pkg::RAND_W-1:0];
			1: w.rtumb = cur_tumble[ltu_pkg::RAND_W-1:0] - 1'b1;
			default: w.rtumb = ltu_pkg::RAND_W'($urandom_range(65535));
		endcase
		if (pick < 5) begin
			w.op = ltu_pkg::OP_NONE;
		end else if (pick < 14) begin
			w.op = ltu_pkg::OP_LOAD;
			w.cprob = pick_prob();
		end else if (pick < 40 || placed_q.size() == 0) begin
			w.op = ltu_pkg::OP_PLACE;
			if (placed_q.size() != 0 && $urandom_range(99) < 15)
				w.idx = ltu_pkg::IDX_W'(placed_q[$urandom_range(placed_q.size() - 1)]);
			// crowd the wrap-around corner so sites fill up
			if ($urandom_range(99) < 75) begin
				w.x = ltu_pkg::X_W'(ltu_pkg::GRID_X - 2 + $urandom_range(4));
				w.y = ltu_pkg::Y_W'(ltu_pkg::GRID_Y - 2 + $urandom_range(3));
			end
		end else begin
			w.op = ltu_pkg::OP_STEP;
			w.idx = ltu_pkg::IDX_W'(placed_q[$urandom_range(placed_q.size() - 1)]);
		end
		return w;
	endfunction

	task automatic queue_word(input word_t w);
		pending.push_back(w);
		queued_cnt++;
	endtask

	task automatic random_words(input int count);
		repeat (count) begin
			while (queued_cnt - accepted_cnt > 8)
				@(negedge clk);
			queue_word(random_word());
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (accepted_cnt != queued_cnt || expected.size() != 0 || busy !== 1'b0);
	endtask

	task automatic write_reg(input ltu_pkg::reg_t which, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (which)
			ltu_pkg::REG_MODE: cur_mode = ltu_pkg::mode_t'(value[1:0]);
			default: cur_tumble = value[ltu_pkg::PROB_W-1:0];
		endcase
	endtask

	task automatic set_phase(input ltu_pkg::mode_t m, input int rate, input int pct);
		wait_idle();
		write_reg(ltu_pkg::REG_MODE, 32'(m));
		write_reg(ltu_pkg::REG_TUMBLE, 32'(rate));
		idle_pct = pct;
	endtask

	initial begin
		foreach (occupancy[i])
			occupancy[i] = '0;
		foreach (col_prob[i])
			col_prob[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_phase(ltu_pkg::MODE_ALWAYS, 0, 0);
		// placement at the corners, a full site and a rejected placement
		queue_word(make_word(ltu_pkg::OP_PLACE, 0, 127, 63, ltu_pkg::DIR_PX, 0, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_PLACE, 32767, 0, 0, ltu_pkg::DIR_MY, 131071, 65535,
			65535, ltu_pkg::DIR_MY));
		queue_word(make_word(ltu_pkg::OP_PLACE, 1, 127, 63, ltu_pkg::DIR_PY, 0, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_PLACE, 2, 127, 63, ltu_pkg::DIR_MX, 0, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_PLACE, 3, 127, 63, ltu_pkg::DIR_PX, 0, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_NONE, 32767, 127, 63, ltu_pkg::DIR_MY, 131071, 65535,
			65535, ltu_pkg::DIR_MY));
		// column loads, saturating one
		queue_word(make_word(ltu_pkg::OP_LOAD, 0, 0, 0, ltu_pkg::DIR_PX, 131071, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_LOAD, 0, 127, 0, ltu_pkg::DIR_PX, 0, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_LOAD, 0, 1, 0, ltu_pkg::DIR_PX, 65536, 0, 0,
			ltu_pkg::DIR_PX));
		// steps that wrap in the +x, +y and -y directions, and one -x step without a wrap
		queue_word(make_word(ltu_pkg::OP_STEP, 0, 0, 0, ltu_pkg::DIR_PX, 0, 65535, 0,
			ltu_pkg::DIR_MX));
		queue_word(make_word(ltu_pkg::OP_STEP, 32767, 0, 0, ltu_pkg::DIR_PX, 0, 0, 65535,
			ltu_pkg::DIR_PY));
		queue_word(make_word(ltu_pkg::OP_STEP, 1, 0, 0, ltu_pkg::DIR_PX, 0, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_STEP, 2, 0, 0, ltu_pkg::DIR_PX, 0, 32768, 0,
			ltu_pkg::DIR_PX));
		// blocked by a full neighbor, then a re-placement
		queue_word(make_word(ltu_pkg::OP_PLACE, 10, 5, 5, ltu_pkg::DIR_PX, 0, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_PLACE, 11, 5, 5, ltu_pkg::DIR_PY, 0, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_PLACE, 12, 5, 5, ltu_pkg::DIR_MX, 0, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_PLACE, 13, 4, 5, ltu_pkg::DIR_PX, 0, 0, 0,
			ltu_pkg::DIR_PX));
		queue_word(make_word(ltu_pkg::OP_STEP, 13, 0, 0, ltu_pkg::DIR_PX, 0, 0, 0,
			ltu_pkg::DIR_MY));
		queue_word(make_word(ltu_pkg::OP_PLACE, 10, 20, 20, ltu_pkg::DIR_MX, 0, 0, 0,
			ltu_pkg::DIR_PX));
		for (int c = 0; c < ltu_pkg::GRID_X; c++)
			queue_word(make_word(ltu_pkg::OP_LOAD, $urandom_range(ltu_pkg::MAX_PARTICLES - 1),
				c, $urandom_range(ltu_pkg::GRID_Y - 1), ltu_pkg::dir_t'($urandom_range(3)),
				pick_prob(), $urandom_range(65535), $urandom_range(65535),
				ltu_pkg::dir_t'($urandom_range(3))));

		set_phase(ltu_pkg::MODE_ALWAYS, 65536, 0);
		// blocked with a tumble, then move and tumble
		queue_word(make_word(ltu_pkg::OP_STEP, 13, 0, 0, ltu_pkg::DIR_PX, 0, 0, 65535,
			ltu_pkg::DIR_MY));
		queue_word(make_word(ltu_pkg::OP_STEP, 13, 0, 0, ltu_pkg::DIR_PX, 0, 65535, 0,
			ltu_pkg::DIR_PX));
		random_words(200);

		set_phase(ltu_pkg::MODE_TABLE, 32768, 59);
		random_words(280);
		set_phase(ltu_pkg::MODE_XONLY, 131071, 0);
		random_words(280);
		set_phase(ltu_pkg::MODE_SPARE, 0, 37);
		random_words(230);
		set_phase(ltu_pkg::MODE_XONLY, 16384, 59);
		random_words(280);
		set_phase(ltu_pkg::MODE_TABLE, 65535, 0);
		random_words(230);
		set_phase(ltu_pkg::MODE_ALWAYS, 1, 37);
		random_words(230);

		wait_idle();
		repeat (10) @(posedge clk);
		if (err_cnt == 0 && expected.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/ltu_pkg.sv
rtl/core/ltu_ram.sv
rtl/core/lattice_run_tumble_update_top.sv
bench/lattice_run_tumble_update_top_tb.sv
